// ===== rtl/pwa_pkg.sv =====
// Shared types and constants for the PID controller with continuous input and anti-windup.
// Holds the register map, the configuration struct and the datapath widths.
// No dependencies; every other file in rtl/ imports this package.
package pwa_pkg;

    localparam int GainW = 32;              // Q16.16 gains and limits
    localparam int InW   = 16;              // sensor units
    localparam int ErrW  = InW + 1;         // error after clamp and wrap
    localparam int DiffW = ErrW + 1;        // error minus previous error
    localparam int PeW   = GainW + ErrW;    // gain times error
    localparam int DeW   = GainW + DiffW;   // gain times error difference
    localparam int ProdW = 2 * GainW;       // integral gain times error sum
    localparam int TestW = ProdW + 1;       // integral test value
    localparam int PdW   = DeW + 1;         // proportional plus derivative
    localparam int ResW  = TestW + 1;       // unclamped drive
    localparam int SumW  = 32;              // stored error sum
    localparam int IdxW  = 3;
    localparam int ModeW = 2;

    localparam int MODE_ENABLE_BIT = 0;
    localparam int MODE_WRAP_BIT   = 1;

    localparam logic signed [GainW-1:0] OUT_LOWER_RST = 32'shFFFF_0000;  // -1.0
    localparam logic signed [GainW-1:0] OUT_UPPER_RST = 32'sh0001_0000;  //  1.0
    localparam logic [ModeW-1:0]        MODE_RST      = 2'b11;

    typedef enum logic [IdxW-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_OUT_LOWER = 3'd3,
        REG_OUT_UPPER = 3'd4,
        REG_IN_LOWER  = 3'd5,
        REG_IN_UPPER  = 3'd6,
        REG_MODE      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
        logic signed [GainW-1:0] out_lower;
        logic signed [GainW-1:0] out_upper;
        logic signed [InW-1:0]   in_lower;
        logic signed [InW-1:0]   in_upper;
        logic [ModeW-1:0]        mode;
    } pwa_cfg_t;

endpackage

// ===== rtl/pid_controller_wrap_antiwindup_core.sv =====
// Top level of the PID controller with continuous input and integrator anti-windup.
// Instantiates pwa_cfg_regs, pwa_error_calc and pwa_integrator; imports pwa_pkg.
//
//   Channel   Signals                                   Direction  Beat
//   --------  ----------------------------------------  ---------  -------------------------
//   in        in_valid, in_ready, measurement, target   sink       one control sample
//   out       out_valid, out_ready, drive               source     one clamped Q16.16 drive
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data sink       one register write
//
// The block takes one sample every cycle unless a stall on out has filled the pipeline;
// each accepted beat reaches the output register through four pipeline stages: error,
// products, integrator update, and final sum with clamp.
// The integrator stage is the only feedback loop; it closes with a single 65-bit add
// and compare because the gain-times-sum product is kept in a register.
// A stall on out holds every full stage; empty stages still fill, so in_ready stays
// high until the pipeline is full. Reset clears all valid bits and the controller state.
// cfg_ready is always high; writes take effect on the next cycle.
module pid_controller_wrap_antiwindup_core
    import pwa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [InW-1:0]   measurement,
    input  logic signed [InW-1:0]   target,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [GainW-1:0] drive,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IdxW-1:0]         cfg_index,
    input  logic [GainW-1:0]        cfg_data
);

    pwa_cfg_t cfg;
    logic     gain_i_wr;
    logic     enable;

    // Stage valid bits and the free chain. A stage is free when it is empty or
    // the stage after it is free, so bubbles collapse during an output stall.
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic free_o, free4, free3, free2, free1;
    logic s2_move, s3_move;

    // Stage payloads.
    logic signed [InW-1:0]   meas_reg;
    logic signed [InW-1:0]   tgt_reg;
    logic signed [ErrW-1:0]  err1;
    logic signed [ErrW-1:0]  err2_reg;
    logic signed [ErrW-1:0]  err3_reg;
    logic signed [ErrW-1:0]  last_error_reg;
    logic signed [DiffW-1:0] diff;
    logic signed [PeW-1:0]   pe;
    logic signed [PeW-1:0]   ie;
    logic signed [DeW-1:0]   de;
    logic signed [PeW-1:0]   pe3_reg;
    logic signed [PeW-1:0]   ie3_reg;
    logic signed [DeW-1:0]   de3_reg;
    logic signed [PdW-1:0]   pd;
    logic signed [TestW-1:0] integ;
    logic signed [PdW-1:0]   pd4_reg;
    logic signed [TestW-1:0] integ4_reg;
    logic signed [ResW-1:0]  res;
    logic signed [GainW-1:0] drive_next;
    logic signed [GainW-1:0] drive_reg;

    assign enable = cfg.mode[MODE_ENABLE_BIT];

    assign free_o   = !out_valid_reg || out_ready;
    assign free4    = !v4_reg || free_o;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign in_ready = free1;

    assign s2_move = v2_reg && free3;
    assign s3_move = v3_reg && free4;

    pwa_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg),
        .gain_i_wr (gain_i_wr)
    );

    // Stage 1: clamp the target, form the error, wrap it in continuous mode.
    pwa_error_calc u_error_calc
    (
        .cfg         (cfg),
        .measurement (meas_reg),
        .target      (tgt_reg),
        .err         (err1)
    );

    // Stage 2: the three gain products. The previous error is updated as each
    // sample leaves this stage while enabled, so the next sample here always sees it.
    assign diff = DiffW'(err2_reg) - DiffW'(last_error_reg);
    assign pe   = PeW'(cfg.gain_p) * PeW'(err2_reg);
    assign ie   = PeW'(cfg.gain_i) * PeW'(err2_reg);
    assign de   = DeW'(cfg.gain_d) * DeW'(diff);

    // Stage 3: integrator update with anti-windup, plus the P and D sum.
    pwa_integrator u_integrator
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .gain_i_wr   (gain_i_wr),
        .gain_i_data (cfg_data),
        .step        (s3_move && enable),
        .err         (err3_reg),
        .ie          (ie3_reg),
        .integ       (integ)
    );

    assign pd = PdW'(pe3_reg) + PdW'(de3_reg);

    // Stage 4: final sum and clamp; crossed limits give upper above upper, else lower.
    assign res = ResW'(pd4_reg) + ResW'(integ4_reg);

    always_comb
    begin
        if (!enable)
        begin
            drive_next = '0;
        end
        else if (res > ResW'(cfg.out_upper))
        begin
            drive_next = cfg.out_upper;
        end
        else if (res < ResW'(cfg.out_lower))
        begin
            drive_next = cfg.out_lower;
        end
        else
        begin
            drive_next = res[GainW-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Valid bits and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_error_reg <= '0;
        end
        else
        begin
            if (free1)
            begin
                v1_reg <= in_valid;
            end
            if (free2)
            begin
                v2_reg <= v1_reg;
            end
            if (free3)
            begin
                v3_reg <= v2_reg;
            end
            if (free4)
            begin
                v4_reg <= v3_reg;
            end
            if (free_o)
            begin
                out_valid_reg <= v4_reg;
            end
            if (s2_move && enable)
            begin
                last_error_reg <= err2_reg;
            end
        end
    end

    // Payload registers follow their stage's free signal and need no reset.
    always_ff @(posedge clk)
    begin
        if (free1)
        begin
            meas_reg <= measurement;
            tgt_reg  <= target;
        end
        if (free2)
        begin
            err2_reg <= err1;
        end
        if (free3)
        begin
            err3_reg <= err2_reg;
            pe3_reg  <= pe;
            ie3_reg  <= ie;
            de3_reg  <= de;
        end
        if (free4)
        begin
            pd4_reg    <= pd;
            integ4_reg <= integ;
        end
        if (free_o)
        begin
            drive_reg <= drive_next;
        end
    end

`ifndef ASSERT_OFF
    // With the output register empty, every stage is free and a sample can enter.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("in_ready low while the output register is empty");

    // A result only appears when the last stage held a sample.
    a_out_from_stage4: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v4_reg))
        else $error("result appeared without a sample in the last stage");

    // The previous error moves only when a sample leaves the product stage.
    a_last_error_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(s2_move) |-> $stable(last_error_reg))
        else $error("previous error changed without a sample leaving stage two");
`endif

endmodule

// ===== rtl/pwa_cfg_regs.sv =====
// Configuration register file for the PID controller.
// Depends on pwa_pkg for the register map and the configuration struct.
module pwa_cfg_regs
    import pwa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [GainW-1:0] cfg_data,
    output logic             cfg_ready,
    output pwa_cfg_t         cfg,
    output logic             gain_i_wr
);

    pwa_cfg_t cfg_reg;
    cfg_idx_t idx;
    logic     wr;

    // Writes land directly in the registers, so the port never pushes back.
    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;
    assign idx       = cfg_idx_t'(cfg_index);
    assign gain_i_wr = wr && (idx == REG_GAIN_I);
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.out_lower <= OUT_LOWER_RST;
            cfg_reg.out_upper <= OUT_UPPER_RST;
            cfg_reg.in_lower  <= '0;
            cfg_reg.in_upper  <= '0;
            cfg_reg.mode      <= MODE_RST;
        end
        else if (wr)
        begin
            case (idx)
                REG_GAIN_P:    cfg_reg.gain_p    <= cfg_data;
                REG_GAIN_I:    cfg_reg.gain_i    <= cfg_data;
                REG_GAIN_D:    cfg_reg.gain_d    <= cfg_data;
                REG_OUT_LOWER: cfg_reg.out_lower <= cfg_data;
                REG_OUT_UPPER: cfg_reg.out_upper <= cfg_data;
                REG_IN_LOWER:  cfg_reg.in_lower  <= cfg_data[InW-1:0];
                REG_IN_UPPER:  cfg_reg.in_upper  <= cfg_data[InW-1:0];
                REG_MODE:      cfg_reg.mode      <= cfg_data[ModeW-1:0];
                default:       ;
            endcase
        end
    end

endmodule

// ===== rtl/pwa_error_calc.sv =====
// Error calculation: target clamp, subtraction and continuous-input wrap.
// Purely combinational; depends on pwa_pkg for widths and the configuration struct.
module pwa_error_calc
    import pwa_pkg::*;
(
    input  pwa_cfg_t               cfg,
    input  logic signed [InW-1:0]  measurement,
    input  logic signed [InW-1:0]  target,
    output logic signed [ErrW-1:0] err
);

    logic signed [ErrW-1:0]  span;
    logic                    span_pos;
    logic signed [InW-1:0]   tgt_c;
    logic signed [ErrW-1:0]  e_raw;
    logic [ErrW-1:0]         mag;
    logic                    do_wrap;
    logic signed [DiffW-1:0] e_adj;

    // The span is only meaningful when the upper bound lies above the lower one.
    assign span     = ErrW'(cfg.in_upper) - ErrW'(cfg.in_lower);
    assign span_pos = !span[ErrW-1] && (span != '0);

    always_comb
    begin
        tgt_c = target;
        if (span_pos && (target > cfg.in_upper))
        begin
            tgt_c = cfg.in_upper;
        end
        else if (span_pos && (target < cfg.in_lower))
        begin
            tgt_c = cfg.in_lower;
        end
    end

    assign e_raw = ErrW'(tgt_c) - ErrW'(measurement);
    assign mag   = e_raw[ErrW-1] ? ErrW'(-e_raw) : e_raw;

    // Wrap when twice the magnitude exceeds the span.
    assign do_wrap = cfg.mode[MODE_WRAP_BIT] && span_pos &&
                     ({mag, 1'b0} > {1'b0, span});

    always_comb
    begin
        e_adj = DiffW'(e_raw);
        if (do_wrap)
        begin
            if (e_raw > ErrW'(0))
            begin
                e_adj = DiffW'(e_raw) - DiffW'(span);
            end
            else
            begin
                e_adj = DiffW'(e_raw) + DiffW'(span);
            end
        end
    end

    assign err = e_adj[ErrW-1:0];

endmodule

// ===== rtl/pwa_integrator.sv =====
// Anti-windup integrator: holds the error sum and its product with the integral gain.
// Depends on pwa_pkg for widths and the configuration struct.
module pwa_integrator
    import pwa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pwa_cfg_t                cfg,
    input  logic                    gain_i_wr,
    input  logic signed [GainW-1:0] gain_i_data,
    input  logic                    step,
    input  logic signed [ErrW-1:0]  err,
    input  logic signed [PeW-1:0]   ie,
    output logic signed [TestW-1:0] integ
);

    logic signed [SumW-1:0]  error_sum_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [SumW:0]    cand;
    logic signed [SumW-1:0]  cand_sat;
    logic signed [TestW-1:0] test;
    logic signed [ProdW-1:0] reload_prod;
    logic                    in_limits;

    // prod_reg always equals gain_i times error_sum_reg. The test product for the
    // candidate sum is then one add away: gain_i * (sum + e) = prod_reg + gain_i * e.
    assign cand = (SumW+1)'(error_sum_reg) + (SumW+1)'(err);
    assign test = TestW'(prod_reg) + TestW'(ie);

    assign in_limits = (test < TestW'(cfg.out_upper)) && (test > TestW'(cfg.out_lower));

    // Saturation only bites when the gain is zero; the product stays correct either way.
    always_comb
    begin
        if (cand[SumW] != cand[SumW-1])
        begin
            cand_sat = cand[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        end
        else
        begin
            cand_sat = cand[SumW-1:0];
        end
    end

    // A new integral gain rescales the stored product against the held sum.
    assign reload_prod = ProdW'(gain_i_data) * ProdW'(error_sum_reg);

    // The integral term of the drive uses the sum after this update.
    assign integ = (step && in_limits) ? test : TestW'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg <= '0;
            prod_reg      <= '0;
        end
        else if (gain_i_wr)
        begin
            prod_reg <= reload_prod;
        end
        else if (step && in_limits)
        begin
            error_sum_reg <= cand_sat;
            prod_reg      <= test[ProdW-1:0];
        end
    end

endmodule

// ===== dv/pwa_tb_pkg.sv =====
`timescale 1ns / 100ps
// Drive scoreboard for the PID controller with continuous input and anti-windup.
// Holds a cycle-free copy of the controller state and the queue of predicted drives.
// Depends on pwa_pkg for widths, reset values and register indexes.
package pwa_tb_pkg;

    import pwa_pkg::*;

    localparam longint SumMax     = 64'sd2147483647;
    localparam longint SumMin     = -64'sd2147483648;
    localparam int     MaxReports = 10;

    class drive_scoreboard;

        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
        logic signed [GainW-1:0] out_lo;
        logic signed [GainW-1:0] out_hi;
        logic signed [InW-1:0]   in_lo;
        logic signed [InW-1:0]   in_hi;
        logic [ModeW-1:0]        mode;

        logic signed [ErrW-1:0]  last_err;
        logic signed [SumW-1:0]  err_sum;

        logic signed [GainW-1:0] expected_drives[$];
        int                      mismatches;
        int                      drive_beats;

        function new();
            gain_p      = '0;
            gain_i      = '0;
            gain_d      = '0;
            out_lo      = OUT_LOWER_RST;
            out_hi      = OUT_UPPER_RST;
            in_lo       = '0;
            in_hi       = '0;
            mode        = MODE_RST;
            last_err    = '0;
            err_sum     = '0;
            mismatches  = 0;
            drive_beats = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [GainW-1:0] data);
            case (idx)
                REG_GAIN_P:    gain_p = data;
                REG_GAIN_I:    gain_i = data;
                REG_GAIN_D:    gain_d = data;
                REG_OUT_LOWER: out_lo = data;
                REG_OUT_UPPER: out_hi = data;
                REG_IN_LOWER:  in_lo  = data[InW-1:0];
                REG_IN_UPPER:  in_hi  = data[InW-1:0];
                REG_MODE:      mode   = data[ModeW-1:0];
                default:       ;
            endcase
        endfunction

        // Advances the controller state by one sample and returns the clamped drive.
        // All products are formed in 64 bits, which holds every sum exactly.
        function logic signed [GainW-1:0] predict_drive(logic signed [InW-1:0] meas,
                                                        logic signed [InW-1:0] tgt);
            longint span;
            longint t;
            longint e;
            longint mag;
            longint cand;
            longint test;
            longint res;
            if (!mode[MODE_ENABLE_BIT])
                return '0;
            span = longint'(in_hi) - longint'(in_lo);
            t = tgt;
            if (span > 0)
            begin
                if (t > in_hi)
                    t = in_hi;
                else if (t < in_lo)
                    t = in_lo;
            end
            e = t - longint'(meas);
            if (mode[MODE_WRAP_BIT] && span > 0)
            begin
                mag = (e < 0) ? -e : e;
                if (2 * mag > span)
                    e = (e > 0) ? e - span : e + span;
            end
            // The sum only moves while the integral term would stay strictly inside
            // the output limits.
            cand = longint'(err_sum) + e;
            test = longint'(gain_i) * cand;
            if (test < out_hi && test > out_lo)
            begin
                if (cand > SumMax)
                    cand = SumMax;
                else if (cand < SumMin)
                    cand = SumMin;
                err_sum = cand[SumW-1:0];
            end
            res = longint'(gain_p) * e + longint'(gain_i) * longint'(err_sum)
                + longint'(gain_d) * (e - longint'(last_err));
            last_err = e[ErrW-1:0];
            if (res > out_hi)
                res = out_hi;
            else if (res < out_lo)
                res = out_lo;
            return res[GainW-1:0];
        endfunction

        function void note_sample(logic signed [InW-1:0] meas, logic signed [InW-1:0] tgt);
            expected_drives.push_back(predict_drive(meas, tgt));
        endfunction

        function void check_drive(logic signed [GainW-1:0] actual);
            logic signed [GainW-1:0] want;
            drive_beats++;
            if (expected_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("drive beat %0d: no drive pending, got %0d (0x%08h)",
                             drive_beats, actual, actual);
                return;
            end
            want = expected_drives.pop_front();
            if (actual !== want)
            begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("drive beat %0d: wanted %0d (0x%08h), got %0d (0x%08h)",
                             drive_beats, want, want, actual, actual);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Top-level testbench for pid_controller_wrap_antiwindup_core: clock, reset, drivers,
// monitor and watchdog. Depends on pwa_pkg and on the scoreboard class in pwa_tb_pkg.
module tb_top;

    import pwa_pkg::*;
    import pwa_tb_pkg::*;

    localparam int ClkHalf      = 4;        // 8 ns period
    localparam int ResetCycles  = 5;
    localparam int WaitMax      = 8;        // longest gap or stall drawn per beat
    localparam int SettleCycles = 12;       // pipeline is four stages deep
    localparam int IdleLimit    = 1000;     // cycles without any beat before giving up
    localparam int RandomItems  = 780;

    // Mode register values: enable is bit 0, continuous wrapping is bit 1.
    localparam logic [ModeW-1:0] ModeDisabled = 2'b00;
    localparam logic [ModeW-1:0] ModePlain    = 2'b01;
    localparam logic [ModeW-1:0] ModeWrapIdle = 2'b10;
    localparam logic [ModeW-1:0] ModeWrap     = 2'b11;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic signed [InW-1:0]   measurement = '0;
    logic signed [InW-1:0]   target      = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic signed [GainW-1:0] drive;
    logic                    cfg_valid   = 1'b0;
    logic                    cfg_ready;
    cfg_idx_t                cfg_index   = REG_GAIN_P;
    logic [GainW-1:0]        cfg_data    = '0;

    drive_scoreboard sb;

    // Pacing controls. A calm side runs without gaps for a stretch.
    bit in_calm  = 1'b0;
    bit out_calm = 1'b0;
    int idle_cycles = 0;
    int random_items;
    int phase_items;

    always #(ClkHalf) clk = ~clk;

    pid_controller_wrap_antiwindup_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .target      (target),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    function automatic int pick_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, WaitMax));
    endfunction

    // Gains: zero, both extremes, any 32-bit value, or a small signed value that
    // keeps the integrator inside typical output limits.
    function automatic logic [GainW-1:0] rand_gain();
        logic [GainW-1:0] v;
        case ($urandom_range(0, 6))
            0:       v = '0;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h0003_0000);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [InW-1:0] pick_between(int lo, int hi);
        int v;
        v = lo + int'($urandom_range(0, hi - lo));
        return v[InW-1:0];
    endfunction

    function automatic logic signed [InW-1:0] pick_extreme(int lo, int hi);
        case ($urandom_range(0, 3))
            0:       return lo[InW-1:0];
            1:       return hi[InW-1:0];
            2:       return 16'sh8000;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Monitor. Everything is sampled at the rising edge, before the drivers' nonblocking
    // updates for that edge land, so each beat is seen exactly as the block saw it.
    // Drive beats are checked before the sample accepted at the same edge is noted;
    // that sample is still in the pipeline, so the two never belong to each other.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_drive(drive);
            if (in_valid && in_ready)
                sb.note_sample(measurement, target);
            if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: a run that stops moving beats for too long has hung.
    initial
    begin
        wait (idle_cycles >= IdleLimit);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver. Before each drive beat it draws a stall, then holds ready high until
    // the beat arrives. A zero stall keeps ready high straight through to the next beat.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            stall = pick_wait(out_calm);
            repeat (stall)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
        end
    end

    // Sends one sample beat after a drawn gap. Valid is only lowered during a gap, so a
    // back-to-back beat never sees valid dropped and raised within one time step.
    task automatic send_sample(logic signed [InW-1:0] meas, logic signed [InW-1:0] tgt);
        int gap;
        gap = pick_wait(in_calm);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        measurement <= meas;
        target      <= tgt;
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(0, 39) == 0)
            in_calm = !in_calm;
    endtask

    // One register write beat. The caller lowers cfg_valid after the last write.
    task automatic write_reg(cfg_idx_t idx, logic [GainW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Writes the whole register file. Unused upper bits of the narrow registers carry
    // random junk, which the block has to ignore.
    task automatic apply_settings(logic [GainW-1:0] gp, logic [GainW-1:0] gi,
                                  logic [GainW-1:0] gd, logic [GainW-1:0] ol,
                                  logic [GainW-1:0] ou, logic [InW-1:0] il,
                                  logic [InW-1:0] iu, logic [ModeW-1:0] md);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_OUT_LOWER, ol);
        write_reg(REG_OUT_UPPER, ou);
        write_reg(REG_IN_LOWER, {16'($urandom), il});
        write_reg(REG_IN_UPPER, {16'($urandom), iu});
        write_reg(REG_MODE, {30'($urandom), md});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every predicted drive has come out, then lets the
    // pipeline settle so that the block is idle before the next register write.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SettleCycles)
            @(posedge clk);
    endtask

    task automatic apply_random_settings();
        logic [GainW-1:0]      ol;
        logic [GainW-1:0]      ou;
        logic [GainW-1:0]      swap32;
        logic signed [InW-1:0] il;
        logic signed [InW-1:0] iu;
        logic signed [InW-1:0] swap16;
        logic [ModeW-1:0]      md;
        case ($urandom_range(0, 5))
            0:
            begin
                ol = 32'h8000_0000;
                ou = 32'h7FFF_FFFF;
            end
            1:
            begin
                // Crossed limits: lower at or above upper.
                ol = $urandom;
                ou = $urandom;
                if ($signed(ol) < $signed(ou))
                begin
                    swap32 = ol;
                    ol = ou;
                    ou = swap32;
                end
            end
            2:
            begin
                ol = OUT_LOWER_RST;
                ou = OUT_UPPER_RST;
            end
            3:
            begin
                ol = $urandom;
                ou = $urandom;
                if ($signed(ol) > $signed(ou))
                begin
                    swap32 = ol;
                    ol = ou;
                    ou = swap32;
                end
            end
            default:
            begin
                ol = -$urandom_range(0, 32'h00FF_FFFF);
                ou = $urandom_range(0, 32'h00FF_FFFF);
            end
        endcase
        case ($urandom_range(0, 5))
            0:
            begin
                // Empty input range: no clamp and no wrap.
                il = 16'($urandom);
                iu = 16'($urandom);
                if (il < iu)
                begin
                    swap16 = il;
                    il = iu;
                    iu = swap16;
                end
            end
            1:
            begin
                il = 16'sh8000;
                iu = 16'sh7FFF;
            end
            2:
            begin
                il = pick_between(-300, -1);
                iu = pick_between(1, 300);
            end
            default:
            begin
                il = 16'($urandom);
                iu = 16'($urandom);
                if (il > iu)
                begin
                    swap16 = il;
                    il = iu;
                    iu = swap16;
                end
            end
        endcase
        case ($urandom_range(0, 7))
            0:       md = ModeDisabled;
            1:       md = ModeWrapIdle;
            2, 3:    md = ModePlain;
            default: md = ModeWrap;
        endcase
        apply_settings(rand_gain(), rand_gain(), rand_gain(), ol, ou, il, iu, md);
    endtask

    // Most samples sit inside the input range, with targets allowed a little past its
    // ends so the clamp gets exercised; the rest are fully random or at the extremes.
    task automatic send_random_sample();
        int                    lo;
        int                    hi;
        int                    tlo;
        int                    thi;
        logic signed [InW-1:0] meas;
        logic signed [InW-1:0] tgt;
        lo = int'(sb.in_lo);
        hi = int'(sb.in_hi);
        if (hi <= lo)
        begin
            lo = -32768;
            hi = 32767;
        end
        tlo = (lo - 64 < -32768) ? -32768 : lo - 64;
        thi = (hi + 64 > 32767) ? 32767 : hi + 64;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                meas = 16'($urandom);
                tgt  = 16'($urandom);
            end
            2:
            begin
                meas = pick_extreme(lo, hi);
                tgt  = pick_extreme(lo, hi);
            end
            default:
            begin
                meas = pick_between(lo, hi);
                tgt  = pick_between(tlo, thi);
            end
        endcase
        send_sample(meas, tgt);
    endtask

    initial
    begin
        sb = new;
        repeat (ResetCycles)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes with an empty input range, so wrapping stays off even though
        // the mode asks for it. The huge negative integral gain rejects every nonzero
        // sum, which leaves the error sum at zero for the next phase.
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, 16'sd0, 16'sd0, ModeWrap);
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sh7FFF, 16'sh7FFF);
        drain();

        // Integral limit at its edge: with gain 1.0 and limits of +-5.0, a sum of 5 is
        // exactly on the upper limit and must be refused. The last sample has an error
        // beyond half the span but wrapping is off.
        apply_settings(32'h0000_0000, 32'h0001_0000, 32'h0000_0000,
                       32'hFFFB_0000, 32'h0005_0000, -16'sd100, 16'sd100, ModePlain);
        send_sample(16'sd0, 16'sd3);
        send_sample(16'sd0, 16'sd2);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd60, 16'sd90);
        drain();

        // Target clamp at both ends, wrap in both directions, and an error of exactly
        // half the span, which stays as it is.
        apply_settings(32'h0001_0000, 32'h0000_0100, 32'hFFFF_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, -16'sd100, 16'sd100, ModeWrap);
        send_sample(16'sd0, 16'sd500);
        send_sample(16'sd0, -16'sd500);
        send_sample(-16'sd60, 16'sd90);
        send_sample(16'sd60, -16'sd90);
        send_sample(16'sd0, 16'sd100);
        send_sample(-16'sd1, 16'sd100);
        send_sample(16'sd100, -16'sd100);
        drain();

        // Crossed output limits, with a reversed input range that disables clamp and wrap.
        apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0000_0000,
                       32'h0003_0000, 32'hFFFD_0000, 16'sd200, -16'sd200, ModeWrap);
        send_sample(16'sd0, 16'sd10);
        send_sample(16'sd10, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1000, -16'sd1000);
        drain();

        // Disabled, with and without the wrap bit: zero drive and untouched state.
        apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, -16'sd100, 16'sd100, ModeDisabled);
        send_sample(16'sd5, -16'sd7);
        send_sample(16'sh8000, 16'sh7FFF);
        drain();
        apply_settings(32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                       32'h8000_0000, 32'h7FFF_FFFF, -16'sd100, 16'sd100, ModeWrapIdle);
        send_sample(16'sd3, 16'sd9);
        drain();

        // Random part: a fresh register setting per phase, drained in between.
        random_items = 0;
        while (random_items < RandomItems)
        begin
            apply_random_settings();
            phase_items = $urandom_range(40, 110);
            repeat (phase_items)
                send_random_sample();
            random_items += phase_items;
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/pwa_pkg.sv
rtl/pwa_cfg_regs.sv
rtl/pwa_error_calc.sv
rtl/pwa_integrator.sv
rtl/pid_controller_wrap_antiwindup_core.sv
dv/pwa_tb_pkg.sv
dv/tb_top.sv
